// File: hdl/hkrb_pkg.sv
// hkrb_pkg: shared types and constants for the HID key report builder.
// No dependencies; the top, front, queue and back files import it.
`timescale 1ns / 1ps

package hkrb_pkg;

    // Layout table
    localparam int MAP_SIZE = 128;
    localparam int MAP_AW   = 7;
    localparam int Q_DEPTH  = 2;

    // Request kinds on the input channel
    localparam logic [2:0] KIND_PRESS       = 3'd0;
    localparam logic [2:0] KIND_RELEASE     = 3'd1;
    localparam logic [2:0] KIND_RELEASE_ALL = 3'd2;
    localparam logic [2:0] KIND_TYPE        = 3'd3;
    localparam logic [2:0] KIND_SEND        = 3'd4;
    localparam logic [2:0] KIND_LOAD_MAP    = 3'd5;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_UNMAPPED = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;

    // Key code ranges and layout flags
    localparam logic [7:0] RAW_BASE         = 8'd136;
    localparam logic [7:0] MOD_BASE         = 8'd128;
    localparam logic [7:0] FLAG_ALTGR       = 8'hC0;
    localparam logic [7:0] FLAG_SHIFT       = 8'h80;
    localparam logic [7:0] USAGE_MASK_ALTGR = 8'h3F;
    localparam logic [7:0] USAGE_MASK_SHIFT = 8'h7F;
    localparam logic [7:0] MOD_BIT_ALTGR    = 8'h40;
    localparam logic [7:0] MOD_BIT_SHIFT    = 8'h02;
    localparam logic [7:0] ISO_FROM         = 8'h32;
    localparam logic [7:0] ISO_TO           = 8'h64;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_PRESS,
        OP_RELEASE,
        OP_RELEASE_ALL,
        OP_TYPE,
        OP_SEND
    } op_t;

    // Classified command handed from the front to the back
    typedef struct packed {
        op_t        op;
        logic       unmapped;
        logic [7:0] usage;
        logic [7:0] mod_mask;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic {
        F_IDLE,
        F_LOOKUP
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_START,
        B_PLACE,
        B_EMIT,
        B_TYPE_REL,
        B_SINGLE
    } back_state_t;

endpackage

// File: hdl/hkrb_if.sv
// hkrb_if: valid/ready channel interfaces for requests and report results.
// Depends on hkrb_pkg for nothing but shares its widths by convention.
`timescale 1ns / 1ps

interface hkrb_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] key_code;
    logic [6:0] map_index;
    logic [7:0] map_value;

    modport source (output valid, kind, key_code, map_index, map_value, input ready);
    modport sink   (input valid, kind, key_code, map_index, map_value, output ready);
endinterface

interface hkrb_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        is_report;
    logic [1:0]  chunk_index;
    logic [7:0]  modifier_bits;
    logic [63:0] slot_bytes;
    logic        last;

    modport source (output valid, status, is_report, chunk_index, modifier_bits,
                    slot_bytes, last, input ready);
    modport sink   (input valid, status, is_report, chunk_index, modifier_bits,
                    slot_bytes, last, output ready);
endinterface

// File: hdl/hid_key_report_builder_top.sv
// hid_key_report_builder_top: top level of the HID key report builder.
// Depends on hkrb_pkg, hkrb_if, hkrb_front, hkrb_cmd_fifo and hkrb_back.
`timescale 1ns / 1ps

// Usage
//   in_ch  : requests (press, release, release all, type, send state, load
//            layout entry), taken when valid and ready are both high.
//   out_ch : results, one per request without a report, otherwise one per
//            group of eight slots (ceil(NUM_SLOTS/8)), twice for a type that
//            placed its key; the final result of a request has last set.
//   cfg_we / cfg_wdata : writes the auto_send bit; write only while idle.
// Flow
//   The front pushes a command in the cycle it takes a request, or from its
//   lookup state when the key code goes through the layout table (registered
//   RAM read). Commands then wait in a two-entry queue, so the front keeps
//   taking requests while the back works. The back classifies and updates
//   the slots in its start state and, for press and type, its place state,
//   then emits the result chunks in turn, holding while out_ch is stalled.
// Reset
//   Slots, modifier byte, auto_send and all layout entries read as zero
//   (unmapped) right after reset; no clearing pass is needed.
// Stalls
//   Results sit in an output register until taken; while out_ch is stalled
//   the back holds, and the queue fills before in_ch.ready drops.

module hid_key_report_builder_top #(
    parameter int NUM_SLOTS = 24
) (
    input  logic      clk,
    input  logic      rst_n,
    hkrb_in_if.sink   in_ch,
    hkrb_out_if.source out_ch,
    input  logic      cfg_we,
    input  logic      cfg_wdata
);
    import hkrb_pkg::*;

    logic       auto_send_reg, auto_send_next;
    logic       q_push;
    logic       q_pop;
    cmd_t       q_push_cmd;
    cmd_t       q_head;
    q_status_t  q_stat;

    // Configuration: single auto_send bit
    assign auto_send_next = cfg_we ? cfg_wdata : auto_send_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_send_reg <= 1'b0;
        end
        else
        begin
            auto_send_reg <= auto_send_next;
        end
    end

    // Front: accept, layout lookup, classification
    hkrb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .q_stat   (q_stat)
    );

    // Command queue decoupling front and back
    hkrb_cmd_fifo #(
        .DEPTH (Q_DEPTH)
    ) u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .q_stat   (q_stat)
    );

    // Back: slot updates and report chunk output
    hkrb_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .auto_send (auto_send_reg),
        .q_stat    (q_stat),
        .head      (q_head),
        .pop       (q_pop),
        .out_ch    (out_ch)
    );

`ifndef SYNTH
    // A full queue must hold off new requests
    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !in_ch.ready)
        else $error("request accepted while command queue full");

    // The front never pushes into a full queue (lookup push relies on this)
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_pop) |-> !q_stat.full)
        else $error("command pushed into full queue");

    // A result without a report is always the only, final one
    a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.is_report) |-> (out_ch.last && out_ch.slot_bytes == 64'd0))
        else $error("non-report result not marked last");
`endif

endmodule

// File: hdl/hkrb_ram.sv
// hkrb_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps

module hkrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/hkrb_front.sv
// hkrb_front: accepts requests, owns the layout table, classifies key codes.
// Depends on hkrb_pkg, hkrb_if and hkrb_ram.
`timescale 1ns / 1ps

module hkrb_front (
    input  logic                  clk,
    input  logic                  rst_n,
    hkrb_in_if.sink               in_ch,
    output logic                  push,
    output hkrb_pkg::cmd_t        push_cmd,
    input  hkrb_pkg::q_status_t   q_stat
);
    import hkrb_pkg::*;

    front_state_t            state_reg, state_next;
    logic [2:0]              kind_reg;
    logic [7:0]              code_reg;
    logic [MAP_SIZE-1:0]     map_valid_reg;
    logic                    hit_valid_reg;
    logic                    accept;
    logic                    needs_map;
    logic                    ram_we;
    logic                    ram_re;
    logic [7:0]              ram_rdata;
    logic [7:0]              entry;

    function automatic cmd_t build_cmd(input logic [2:0] kind, input logic [7:0] code,
                                       input logic [7:0] ent);
        cmd_t       c;
        logic [7:0] k;
        logic       keyed;
        c = '0;
        k = ent;
        case (kind)
            KIND_PRESS:       c.op = OP_PRESS;
            KIND_RELEASE:     c.op = OP_RELEASE;
            KIND_RELEASE_ALL: c.op = OP_RELEASE_ALL;
            KIND_TYPE:        c.op = OP_TYPE;
            KIND_SEND:        c.op = OP_SEND;
            default:          c.op = OP_NOP;
        endcase
        keyed = (kind == KIND_PRESS) || (kind == KIND_RELEASE) || (kind == KIND_TYPE);
        if (code >= RAW_BASE)
        begin
            c.usage = code - RAW_BASE;
        end
        else if (code >= MOD_BASE)
        begin
            c.mod_mask = 8'd1 << code[2:0];
        end
        else if (k == 8'd0)
        begin
            c.unmapped = keyed;
        end
        else
        begin
            if ((k & FLAG_ALTGR) == FLAG_ALTGR)
            begin
                c.mod_mask = MOD_BIT_ALTGR;
                k = k & USAGE_MASK_ALTGR;
            end
            else if ((k & FLAG_SHIFT) == FLAG_SHIFT)
            begin
                c.mod_mask = MOD_BIT_SHIFT;
                k = k & USAGE_MASK_SHIFT;
            end
            if (k == ISO_FROM)
            begin
                k = ISO_TO;
            end
            c.usage = k;
        end
        return c;
    endfunction

    hkrb_ram #(
        .WIDTH (8),
        .DEPTH (MAP_SIZE)
    ) u_layout_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_ch.map_index),
        .wdata (in_ch.map_value),
        .re    (ram_re),
        .raddr (in_ch.key_code[MAP_AW-1:0]),
        .rdata (ram_rdata)
    );

    assign accept    = in_ch.valid && in_ch.ready;
    assign needs_map = ((in_ch.kind == KIND_PRESS) || (in_ch.kind == KIND_RELEASE) ||
                        (in_ch.kind == KIND_TYPE)) && !in_ch.key_code[7];
    // Entries never written read as unmapped
    assign entry     = hit_valid_reg ? ram_rdata : 8'd0;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept && needs_map)
                begin
                    state_next = F_LOOKUP;
                end
            end
            F_LOOKUP: state_next = F_IDLE;
            default:  state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        in_ch.ready = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        push        = 1'b0;
        push_cmd    = build_cmd(in_ch.kind, in_ch.key_code, 8'd0);
        case (state_reg)
            F_IDLE:
            begin
                in_ch.ready = !q_stat.full;
                ram_we      = accept && (in_ch.kind == KIND_LOAD_MAP);
                ram_re      = accept && needs_map;
                push        = accept && !needs_map;
            end
            F_LOOKUP:
            begin
                push     = 1'b1;
                push_cmd = build_cmd(kind_reg, code_reg, entry);
            end
            default:
            begin
                in_ch.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            map_valid_reg <= '0;
            hit_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ram_we)
            begin
                map_valid_reg[in_ch.map_index] <= 1'b1;
            end
            if (ram_re)
            begin
                hit_valid_reg <= map_valid_reg[in_ch.key_code[MAP_AW-1:0]];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= in_ch.kind;
            code_reg <= in_ch.key_code;
        end
    end

endmodule

// File: hdl/hkrb_cmd_fifo.sv
// hkrb_cmd_fifo: short command queue between the front and the back.
// Depends on hkrb_pkg.
`timescale 1ns / 1ps

module hkrb_cmd_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  hkrb_pkg::cmd_t       push_cmd,
    input  logic                 pop,
    output hkrb_pkg::cmd_t       head,
    output hkrb_pkg::q_status_t  q_stat
);
    import hkrb_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign head         = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CW'(DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: hdl/hkrb_back.sv
// hkrb_back: key slot array, modifier byte and report chunk sequencer.
// Depends on hkrb_pkg and hkrb_if.
`timescale 1ns / 1ps

module hkrb_back #(
    parameter int NUM_SLOTS = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 auto_send,
    input  hkrb_pkg::q_status_t  q_stat,
    input  hkrb_pkg::cmd_t       head,
    output logic                 pop,
    hkrb_out_if.source           out_ch
);
    import hkrb_pkg::*;

    localparam int NUM_CHUNKS = (NUM_SLOTS + 7) / 8;
    localparam int CHUNK_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

    back_state_t                  state_reg, state_next;
    cmd_t                         cmd_reg, cmd_next;
    logic [NUM_SLOTS-1:0][7:0]    slots_reg, slots_next;
    logic [7:0]                   mod_reg, mod_next;
    logic [1:0]                   status_reg, status_next;
    logic                         final_reg, final_next;
    logic [CHUNK_W-1:0]           chunk_reg, chunk_next;
    logic [NUM_SLOTS-1:0]         match_reg, match_next;
    logic [NUM_SLOTS-1:0]         empty_reg, empty_next;
    logic [NUM_SLOTS-1:0]         first_empty;
    logic [NUM_CHUNKS-1:0][63:0]  chunk_words;
    logic                         placed;
    logic                         chunk_last;
    logic                         out_load;

    logic                         out_valid_reg, out_valid_next;
    logic [1:0]                   out_status_reg, out_status_next;
    logic                         out_is_report_reg, out_is_report_next;
    logic [1:0]                   out_chunk_reg, out_chunk_next;
    logic [7:0]                   out_mod_reg, out_mod_next;
    logic [63:0]                  out_bytes_reg, out_bytes_next;
    logic                         out_last_reg, out_last_next;

    assign placed      = (|match_reg) || (|empty_reg);
    assign first_empty = empty_reg & (~empty_reg + 1'b1);
    assign chunk_last  = (chunk_reg == CHUNK_W'(NUM_CHUNKS - 1));
    assign out_load    = ((state_reg == B_EMIT) || (state_reg == B_SINGLE)) &&
                         (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        chunk_words = '0;
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            chunk_words[s / 8][(s % 8) * 8 +: 8] = slots_reg[s];
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            match_next[i] = (slots_reg[i] == cmd_reg.usage);
            empty_next[i] = (slots_reg[i] == 8'd0);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = B_START;
                end
            end
            B_START:
            begin
                case (cmd_reg.op)
                    OP_PRESS, OP_TYPE:
                        state_next = cmd_reg.unmapped ? B_SINGLE : B_PLACE;
                    OP_RELEASE:
                        state_next = (!cmd_reg.unmapped && auto_send) ? B_EMIT : B_SINGLE;
                    OP_RELEASE_ALL:
                        state_next = auto_send ? B_EMIT : B_SINGLE;
                    OP_SEND:
                        state_next = B_EMIT;
                    default:
                        state_next = B_SINGLE;
                endcase
            end
            B_PLACE:
            begin
                if (cmd_reg.op == OP_TYPE)
                begin
                    state_next = placed ? B_EMIT : B_TYPE_REL;
                end
                else
                begin
                    state_next = (placed && auto_send) ? B_EMIT : B_SINGLE;
                end
            end
            B_EMIT:
            begin
                if (out_load && chunk_last)
                begin
                    state_next = final_reg ? B_IDLE : B_TYPE_REL;
                end
            end
            B_TYPE_REL: state_next = B_EMIT;
            B_SINGLE:
            begin
                if (out_load)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        pop                = 1'b0;
        cmd_next           = cmd_reg;
        slots_next         = slots_reg;
        mod_next           = mod_reg;
        status_next        = status_reg;
        final_next         = final_reg;
        chunk_next         = chunk_reg;
        out_status_next    = out_status_reg;
        out_is_report_next = out_is_report_reg;
        out_chunk_next     = out_chunk_reg;
        out_mod_next       = out_mod_reg;
        out_bytes_next     = out_bytes_reg;
        out_last_next      = out_last_reg;
        out_valid_next     = out_ch.ready ? 1'b0 : out_valid_reg;

        case (state_reg)
            B_IDLE:
            begin
                pop      = !q_stat.empty;
                cmd_next = head;
            end
            B_START:
            begin
                final_next  = 1'b1;
                status_next = cmd_reg.unmapped ? STATUS_UNMAPPED : STATUS_OK;
                if (!cmd_reg.unmapped)
                begin
                    case (cmd_reg.op)
                        OP_PRESS, OP_TYPE:
                            mod_next = mod_reg | cmd_reg.mod_mask;
                        OP_RELEASE:
                        begin
                            mod_next = mod_reg & ~cmd_reg.mod_mask;
                            for (int i = 0; i < NUM_SLOTS; i++)
                            begin
                                if (cmd_reg.usage != 8'd0 && slots_reg[i] == cmd_reg.usage)
                                begin
                                    slots_next[i] = 8'd0;
                                end
                            end
                        end
                        OP_RELEASE_ALL:
                        begin
                            mod_next   = 8'd0;
                            slots_next = '0;
                        end
                        default:
                            mod_next = mod_reg;
                    endcase
                end
            end
            B_PLACE:
            begin
                status_next = placed ? STATUS_OK : STATUS_FULL;
                final_next  = (cmd_reg.op != OP_TYPE);
                if (!(|match_reg))
                begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (first_empty[i])
                        begin
                            slots_next[i] = cmd_reg.usage;
                        end
                    end
                end
            end
            B_TYPE_REL:
            begin
                final_next = 1'b1;
                mod_next   = mod_reg & ~cmd_reg.mod_mask;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (cmd_reg.usage != 8'd0 && slots_reg[i] == cmd_reg.usage)
                    begin
                        slots_next[i] = 8'd0;
                    end
                end
            end
            B_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next     = 1'b1;
                    out_status_next    = status_reg;
                    out_is_report_next = 1'b1;
                    out_chunk_next     = 2'(chunk_reg);
                    out_mod_next       = mod_reg;
                    out_bytes_next     = chunk_words[chunk_reg];
                    out_last_next      = final_reg && chunk_last;
                    chunk_next         = chunk_last ? '0 : chunk_reg + 1'b1;
                end
            end
            B_SINGLE:
            begin
                if (out_load)
                begin
                    out_valid_next     = 1'b1;
                    out_status_next    = status_reg;
                    out_is_report_next = 1'b0;
                    out_chunk_next     = 2'd0;
                    out_mod_next       = 8'd0;
                    out_bytes_next     = 64'd0;
                    out_last_next      = 1'b1;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            slots_reg     <= '0;
            mod_reg       <= 8'd0;
            status_reg    <= STATUS_OK;
            final_reg     <= 1'b1;
            chunk_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slots_reg     <= slots_next;
            mod_reg       <= mod_next;
            status_reg    <= status_next;
            final_reg     <= final_next;
            chunk_reg     <= chunk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg           <= cmd_next;
        match_reg         <= match_next;
        empty_reg         <= empty_next;
        out_status_reg    <= out_status_next;
        out_is_report_reg <= out_is_report_next;
        out_chunk_reg     <= out_chunk_next;
        out_mod_reg       <= out_mod_next;
        out_bytes_reg     <= out_bytes_next;
        out_last_reg      <= out_last_next;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.status        = out_status_reg;
    assign out_ch.is_report     = out_is_report_reg;
    assign out_ch.chunk_index   = out_chunk_reg;
    assign out_ch.modifier_bits = out_mod_reg;
    assign out_ch.slot_bytes    = out_bytes_reg;
    assign out_ch.last          = out_last_reg;

endmodule
